// ===== rtl/rsa_mexp_pkg.sv =====
// Shared constants and controller/datapath interface types for the RSA exponentiation engine.
package rsa_mexp_pkg;

  localparam int DEFAULT_WIDTH = 40;

  // Configuration register indexes.
  localparam int CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] REG_MODULUS          = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_PUBLIC_EXPONENT  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_PRIVATE_EXPONENT = 2'd2;

  // Input operation codes.
  localparam logic OP_ENCRYPT = 1'b0;
  localparam logic OP_DECRYPT = 1'b1;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;         // capture operands, clear the step counter
    logic red_step;     // one restoring-division step of the input reduction
    logic mul_start_a;  // start acc * base
    logic mul_start_sq; // start base * base
    logic mul_step;     // one shift-add step of the modular multiplier
    logic fin_a;        // write the product to acc
    logic fin_sq;       // write the product to base
    logic shift_exp;    // drop the lowest exponent bit
    logic out_load;     // move the final value to the output register
  } rsa_mexp_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic m_le1;
    logic expo_zero;
    logic expo_bit0;
    logic expo_last;
    logic cnt_last;
  } rsa_mexp_stat_t;

endpackage

// ===== rtl/rsa_mexp_dp.sv =====
// Datapath: operand registers, input reduction and the shared shift-add modular multiplier.
module rsa_mexp_dp import rsa_mexp_pkg::*; #(
  parameter int WIDTH = DEFAULT_WIDTH
) (
  input  logic                 clk,
  input  rsa_mexp_cmd_t        cmd,
  output rsa_mexp_stat_t       stat,
  input  logic [WIDTH-1:0]     modulus,
  input  logic [WIDTH-1:0]     expo_in,
  input  logic [WIDTH-1:0]     value_in,
  output logic [WIDTH-1:0]     result
);

  localparam int CW = $clog2(WIDTH);
  localparam logic [CW-1:0] CNT_LAST = CW'(WIDTH - 1);

  logic [WIDTH-1:0] m;
  logic [WIDTH-1:0] expo;
  logic [WIDTH-1:0] vsh;
  logic [WIDTH-1:0] rem;
  logic [WIDTH-1:0] acc;
  logic [WIDTH-1:0] base;
  logic [WIDTH-1:0] macc;
  logic [WIDTH-1:0] mx;
  logic [WIDTH-1:0] my;
  logic [CW-1:0]    cnt;
  logic [WIDTH-1:0] res;

  logic [WIDTH:0]   rem_t;
  logic [WIDTH-1:0] rem_next;
  logic [WIDTH:0]   dbl;
  logic [WIDTH-1:0] dbl_red;
  logic [WIDTH:0]   sum;
  logic [WIDTH-1:0] macc_next;

  // One restoring-division step: shift in the next value bit, subtract if it fits.
  always_comb begin
    rem_t = {rem, vsh[WIDTH-1]};
    if (rem_t >= {1'b0, m}) begin
      rem_next = rem_t[WIDTH-1:0] - m;
    end else begin
      rem_next = rem_t[WIDTH-1:0];
    end
  end

  // One multiplier step: acc = 2*acc mod m, then add x mod m when the multiplier bit is set.
  always_comb begin
    dbl = {macc, 1'b0};
    if (dbl >= {1'b0, m}) begin
      dbl_red = dbl[WIDTH-1:0] - m;
    end else begin
      dbl_red = dbl[WIDTH-1:0];
    end
    sum = {1'b0, dbl_red} + (my[WIDTH-1] ? {1'b0, mx} : {(WIDTH + 1){1'b0}});
    if (sum >= {1'b0, m}) begin
      macc_next = sum[WIDTH-1:0] - m;
    end else begin
      macc_next = sum[WIDTH-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      m    <= modulus;
      expo <= expo_in;
      vsh  <= value_in;
      rem  <= '0;
      cnt  <= '0;
    end

    if (cmd.red_step) begin
      rem <= rem_next;
      vsh <= {vsh[WIDTH-2:0], 1'b0};
      cnt <= cnt + 1'b1;
      if (cnt == CNT_LAST) begin
        base <= rem_next;
        acc  <= {{(WIDTH - 1){1'b0}}, 1'b1};
      end
    end

    // A product that finishes in the same cycle as a new one starts hands the multiplier over.
    if (cmd.mul_start_a || cmd.mul_start_sq) begin
      macc <= '0;
      mx   <= cmd.mul_start_a ? acc : base;
      my   <= base;
      cnt  <= '0;
    end else if (cmd.mul_step) begin
      macc <= macc_next;
      my   <= {my[WIDTH-2:0], 1'b0};
      cnt  <= cnt + 1'b1;
    end
    if (cmd.fin_a) begin
      acc <= macc_next;
    end
    if (cmd.fin_sq) begin
      base <= macc_next;
    end

    if (cmd.shift_exp) begin
      expo <= {1'b0, expo[WIDTH-1:1]};
    end

    if (cmd.out_load) begin
      res <= stat.m_le1 ? '0 : acc;
    end
  end

  assign stat.m_le1     = (m[WIDTH-1:1] == '0);
  assign stat.expo_zero = (expo == '0);
  assign stat.expo_bit0 = expo[0];
  assign stat.expo_last = (expo[WIDTH-1:1] == '0);
  assign stat.cnt_last  = (cnt == CNT_LAST);

  assign result = res;

endmodule

// ===== rtl/rsa_mexp_ctrl.sv =====
// Controller: sequences reduction, square-and-multiply steps and the output handshake.
module rsa_mexp_ctrl import rsa_mexp_pkg::*; (
  input  logic           clk,
  input  logic           rst,
  input  logic           in_valid,
  output logic           in_stall,
  output logic           out_valid,
  input  logic           out_stall,
  input  rsa_mexp_stat_t stat,
  output rsa_mexp_cmd_t  cmd
);

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_REDUCE = 3'd1;
  localparam logic [2:0] S_CHECK  = 3'd2;
  localparam logic [2:0] S_MULA   = 3'd3;
  localparam logic [2:0] S_MULSQ  = 3'd4;
  localparam logic [2:0] S_DONE   = 3'd5;

  logic [2:0] state;
  logic [2:0] state_next;
  logic       out_valid_next;

  always_comb begin
    cmd        = '0;
    state_next = state;
    case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load   = 1'b1;
          state_next = S_REDUCE;
        end
      end
      S_REDUCE: begin
        cmd.red_step = 1'b1;
        if (stat.cnt_last) begin
          state_next = S_CHECK;
        end
      end
      S_CHECK: begin
        if (stat.m_le1 || stat.expo_zero) begin
          state_next = S_DONE;
        end else if (stat.expo_bit0) begin
          cmd.mul_start_a = 1'b1;
          state_next      = S_MULA;
        end else begin
          cmd.shift_exp    = 1'b1;
          cmd.mul_start_sq = 1'b1;
          state_next       = S_MULSQ;
        end
      end
      S_MULA: begin
        cmd.mul_step = 1'b1;
        if (stat.cnt_last) begin
          cmd.fin_a = 1'b1;
          if (stat.expo_last) begin
            state_next = S_DONE;
          end else begin
            cmd.shift_exp    = 1'b1;
            cmd.mul_start_sq = 1'b1;
            state_next       = S_MULSQ;
          end
        end
      end
      S_MULSQ: begin
        cmd.mul_step = 1'b1;
        if (stat.cnt_last) begin
          cmd.fin_sq = 1'b1;
          state_next = S_CHECK;
        end
      end
      S_DONE: begin
        // The output register may still hold the previous result.
        if (!out_valid || !out_stall) begin
          cmd.out_load = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  assign out_valid_next = cmd.out_load | (out_valid & out_stall);

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      out_valid <= out_valid_next;
    end
  end

  assign in_stall = (state != S_IDLE);

endmodule

// ===== rtl/rsa_modular_exponentiation_top.sv =====
// Top level of the RSA modular exponentiation engine: configuration registers and core.
//
// Each transaction on the input channel gives one result, value^exponent mod modulus, where the
// exponent is public_exponent for op = 0 and private_exponent for op = 1. One item is worked at a
// time: the input is stalled from acceptance until the result is moved to the output register.
// An item is first reduced modulo the modulus by restoring division; then, for every exponent
// bit up to the highest set one, there is one bookkeeping state plus a modular product for each
// multiply (when the bit is set) and each square (for every bit below the highest set one). The
// item is accepted in the idle state and handed off from the done state. A modulus of 0 or 1 or
// a zero exponent finishes right after the reduction. The run time is set by the single shift-add
// modular multiplier, which retires one multiplier bit per cycle. The output register lets the
// next item be accepted while a finished result waits.
// Configuration is written through cfg_valid/cfg_index/cfg_data, always ready, and must only be
// written while the engine is idle.
module rsa_modular_exponentiation_top import rsa_mexp_pkg::*; #(
  parameter int WIDTH = DEFAULT_WIDTH
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [WIDTH-1:0]     cfg_data,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  logic                 op,
  input  logic [WIDTH-1:0]     value,
  output logic                 out_valid,
  input  logic                 out_stall,
  output logic [WIDTH-1:0]     result
);

  logic [WIDTH-1:0] modulus;
  logic [WIDTH-1:0] public_exponent;
  logic [WIDTH-1:0] private_exponent;
  logic [WIDTH-1:0] expo_sel;

  rsa_mexp_cmd_t  cmd;
  rsa_mexp_stat_t stat;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      modulus          <= {{(WIDTH - 1){1'b0}}, 1'b1};
      public_exponent  <= {{(WIDTH - 1){1'b0}}, 1'b1};
      private_exponent <= {{(WIDTH - 1){1'b0}}, 1'b1};
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_MODULUS:          modulus          <= cfg_data;
        REG_PUBLIC_EXPONENT:  public_exponent  <= cfg_data;
        REG_PRIVATE_EXPONENT: private_exponent <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  assign expo_sel = (op == OP_DECRYPT) ? private_exponent : public_exponent;

  rsa_mexp_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .stat      (stat),
    .cmd       (cmd)
  );

  rsa_mexp_dp #(
    .WIDTH (WIDTH)
  ) u_dp (
    .clk      (clk),
    .cmd      (cmd),
    .stat     (stat),
    .modulus  (modulus),
    .expo_in  (expo_sel),
    .value_in (value),
    .result   (result)
  );

endmodule

// ===== rtl/rsa_mexp_checker.sv =====
// Port-level checker for the RSA exponentiation engine, bound to the top level.
module rsa_mexp_checker import rsa_mexp_pkg::*; #(
  parameter int WIDTH = DEFAULT_WIDTH
) (
  input logic             clk,
  input logic             rst,
  input logic             in_valid,
  input logic             in_stall,
  input logic             out_valid,
  input logic             out_stall,
  input logic [WIDTH-1:0] result
);

  // After reset the engine is idle with no result pending.
  assert property (@(posedge clk) rst |=> (!out_valid && !in_stall))
    else $error("engine not idle after reset");

  // One item at a time: an accepted transaction makes the engine busy.
  assert property (@(posedge clk) disable iff (rst)
    (in_valid && !in_stall) |=> in_stall)
    else $error("input taken while a transaction is in progress");

  // A new result only appears at the end of a transaction's work.
  assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(in_stall))
    else $error("result presented without a transaction in progress");

  // A stalled result stays put.
  assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_stall) |=> (out_valid && $stable(result)))
    else $error("stalled result changed");

endmodule

bind rsa_modular_exponentiation_top rsa_mexp_checker #(
  .WIDTH (WIDTH)
) u_rsa_mexp_checker (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (in_valid),
  .in_stall  (in_stall),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .result    (result)
);

// ===== sim/rsa_modular_exponentiation_top_tb.sv =====
// Self-checking testbench for the RSA modular exponentiation engine.
module rsa_modular_exponentiation_top_tb;
  import rsa_mexp_pkg::*;

  localparam int W = DEFAULT_WIDTH;
  localparam logic [W-1:0] MAXV = {W{1'b1}};
  localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 2'd3;
  localparam int N_DIRECTED = 21;
  localparam int N_PHASES = 7;
  localparam int ITEMS_PER_PHASE = 21;
  localparam int LONG_HOLD = 6000;
  localparam int SETTLE = 4;
  localparam int TAIL = 200;

  typedef struct packed {
    logic [W-1:0] modulus;
    logic [W-1:0] pub_e;
    logic [W-1:0] priv_d;
    logic         op;
    logic [W-1:0] val;
    logic         known;
    logic [W-1:0] res;
  } vec_t;

  typedef struct {
    int           tag;
    logic [W-1:0] res;
  } power_t;

  logic                 clk = 1'b0;
  logic                 rst;
  logic                 cfg_valid;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [W-1:0]         cfg_data;
  logic                 in_valid;
  logic                 in_stall;
  logic                 op;
  logic [W-1:0]         value;
  logic                 out_valid;
  logic                 out_stall;
  logic [W-1:0]         result;

  // Register copies kept in step with every completed configuration write.
  logic [W-1:0] cfg_mod = 1;
  logic [W-1:0] cfg_pub = 1;
  logic [W-1:0] cfg_priv = 1;

  power_t awaited_powers[$];
  power_t head;
  bit     hold_req = 1'b0;
  bit     calm = 1'b0;
  int     n_items = 0;
  int     n_dec = 0;
  int     n_settings = 1;
  int     n_results = 0;
  int     mismatches = 0;

  rsa_modular_exponentiation_top #(.WIDTH(W)) dut (
    .clk      (clk),
    .rst      (rst),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .op       (op),
    .value    (value),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .result   (result)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  initial begin
    #6000000;
    $display("rsa_modular_exponentiation_top test failed");
    $finish;
  end

  // Right-to-left square-and-multiply with every product kept at double width.
  function automatic logic [W-1:0] modexp(input logic [W-1:0] base, input logic [W-1:0] expo,
                                          input logic [W-1:0] m);
    logic [2*W-1:0] a2;
    logic [2*W-1:0] b2;
    logic [W-1:0]   acc;
    logic [W-1:0]   sq;
    logic [W-1:0]   ex;
    if (m <= 1) return '0;
    acc = 1;
    sq = base % m;
    ex = expo;
    while (ex != 0) begin
      if (ex[0]) begin
        a2 = {{W{1'b0}}, acc};
        b2 = {{W{1'b0}}, sq};
        acc = W'((a2 * b2) % m);
      end
      a2 = {{W{1'b0}}, sq};
      sq = W'((a2 * a2) % m);
      ex = ex >> 1;
    end
    return acc;
  endfunction

  function automatic logic [W-1:0] rand_bits(input int n);
    logic [63:0] r;
    r = {$urandom, $urandom};
    if (n == 0) return '0;
    return W'(r & ((64'd1 << n) - 1));
  endfunction

  function automatic logic [W-1:0] top_bit(input int n);
    return rand_bits(n) | (W'(1) << (n - 1));
  endfunction

  function automatic logic [W-1:0] pick_value();
    case ($urandom_range(0, 9))
      0: return '0;
      1: return cfg_mod - 1;
      2: return cfg_mod;
      3: return MAXV;
      4, 5: return rand_bits($urandom_range(1, W));
      default: return rand_bits(W);
    endcase
  endfunction

  function automatic vec_t vec(input logic [W-1:0] m, input logic [W-1:0] e,
                               input logic [W-1:0] d, input logic o, input logic [W-1:0] v,
                               input logic k, input logic [W-1:0] r);
    vec_t t;
    t.modulus = m;
    t.pub_e = e;
    t.priv_d = d;
    t.op = o;
    t.val = v;
    t.known = k;
    t.res = r;
    return t;
  endfunction

  // Directed stimulus; the result column is used only where known is set.
  function automatic vec_t directed_vec(input int idx);
    case (idx)
      0: return vec(1, 1, 1, OP_ENCRYPT, 123, 1, 0);
      1: return vec(1, 1, 1, OP_DECRYPT, MAXV, 1, 0);
      2: return vec(0, 5, 7, OP_ENCRYPT, 12345, 1, 0);
      3: return vec(0, 5, 7, OP_DECRYPT, MAXV, 1, 0);
      4: return vec(1000, 0, 2, OP_ENCRYPT, 5, 1, 1);
      5: return vec(1000, 0, 2, OP_DECRYPT, 30, 1, 900);
      6: return vec(1000, 1, 0, OP_ENCRYPT, 123456, 1, 456);
      7: return vec(1000, 1, 0, OP_DECRYPT, MAXV, 1, 1);
      8: return vec(3233, 17, 2753, OP_ENCRYPT, 65, 1, 2790);
      9: return vec(3233, 17, 2753, OP_DECRYPT, 2790, 1, 65);
      10: return vec(3233, 17, 2753, OP_ENCRYPT, 0, 1, 0);
      11: return vec(3233, 17, 2753, OP_DECRYPT, 1, 1, 1);
      12: return vec(MAXV, 1, MAXV, OP_ENCRYPT, MAXV - 1, 1, MAXV - 1);
      13: return vec(MAXV, 1, MAXV, OP_ENCRYPT, MAXV, 1, 0);
      14: return vec(MAXV, 1, MAXV, OP_DECRYPT, MAXV - 1, 0, 0);
      15: return vec(MAXV, MAXV, MAXV, OP_ENCRYPT, 40'h80_0000_0001, 0, 0);
      16: return vec(40'h80_0000_0000, 3, MAXV, OP_ENCRYPT, MAXV, 0, 0);
      17: return vec(40'h80_0000_0000, 3, MAXV, OP_DECRYPT, 40'h55_5555_5555, 0, 0);
      18: return vec(2, MAXV, MAXV, OP_ENCRYPT, MAXV, 1, 1);
      19: return vec(2, MAXV, MAXV, OP_DECRYPT, 40'hAA_AAAA_AAAA, 1, 0);
      default: return vec(40'hFF_FFFF_FFFB, 65537, MAXV, OP_ENCRYPT, 40'h12_3456_789A, 0, 0);
    endcase
  endfunction

  // Leaves cfg_valid high so back-to-back writes need no toggle; the caller lowers it.
  task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx, input logic [W-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      REG_MODULUS: cfg_mod = data;
      REG_PUBLIC_EXPONENT: cfg_pub = data;
      REG_PRIVATE_EXPONENT: cfg_priv = data;
      default: begin end
    endcase
  endtask

  task automatic wait_idle();
    in_valid <= 1'b0;
    while (awaited_powers.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic program_regs(input logic [W-1:0] m, input logic [W-1:0] e,
                              input logic [W-1:0] d, input bit stray);
    wait_idle();
    cfg_write(REG_MODULUS, m);
    cfg_write(REG_PUBLIC_EXPONENT, e);
    cfg_write(REG_PRIVATE_EXPONENT, d);
    // A write to the unused index must leave every register untouched.
    if (stray) cfg_write(REG_UNUSED, rand_bits(W));
    cfg_valid <= 1'b0;
    n_settings++;
  endtask

  task automatic send_item(input logic o, input logic [W-1:0] v, input logic known,
                           input logic [W-1:0] typed);
    power_t p;
    if (!calm && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 17)) @(posedge clk);
    end
    in_valid <= 1'b1;
    op <= o;
    value <= v;
    do @(posedge clk); while (in_stall);
    p.tag = n_items;
    p.res = known ? typed : modexp(v, (o == OP_DECRYPT) ? cfg_priv : cfg_pub, cfg_mod);
    awaited_powers.push_back(p);
    n_items++;
    if (o == OP_DECRYPT) n_dec++;
  endtask

  // Output side: random stall bursts, plus one long hold-off on request.
  initial begin
    out_stall = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_req) begin
        hold_req = 1'b0;
        out_stall <= 1'b1;
        repeat (LONG_HOLD) @(posedge clk);
        out_stall <= 1'b0;
      end else if (!calm && $urandom_range(0, 5) == 0) begin
        out_stall <= 1'b1;
        repeat ($urandom_range(1, 17)) @(posedge clk);
        out_stall <= 1'b0;
      end
    end
  end

  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) begin
      n_results++;
      if (awaited_powers.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("Unexpected result %h with nothing pending", result);
      end else begin
        head = awaited_powers.pop_front();
        if (result !== head.res) begin
          mismatches++;
          if (mismatches <= 10)
            $display("Transaction %0d: result expected %h, got %h", head.tag, head.res, result);
        end
      end
    end
  end

  initial begin
    vec_t row;
    rst = 1'b1;
    cfg_valid = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    in_valid = 1'b0;
    op = OP_ENCRYPT;
    value = '0;
    repeat (6) @(posedge clk);
    rst <= 1'b0;

    for (int i = 0; i < N_DIRECTED; i++) begin
      row = directed_vec(i);
      if (row.modulus != cfg_mod || row.pub_e != cfg_pub || row.priv_d != cfg_priv)
        program_regs(row.modulus, row.pub_e, row.priv_d, 1'b0);
      send_item(row.op, row.val, row.known, row.res);
    end

    for (int ph = 0; ph < N_PHASES; ph++) begin
      case (ph)
        0: program_regs(top_bit(W), 65537, rand_bits(W), 1'b0);
        1: program_regs(top_bit($urandom_range(2, 12)), rand_bits($urandom_range(0, 12)),
                        rand_bits($urandom_range(0, 12)), 1'b0);
        2: program_regs(MAXV, MAXV, MAXV, 1'b0);
        3: program_regs(W'($urandom_range(0, 1)), rand_bits(W), rand_bits(W), 1'b0);
        4: begin
          // Short items so the engine and its output register fill during the hold-off.
          program_regs(top_bit(20), rand_bits(6), rand_bits(6), 1'b0);
          hold_req = 1'b1;
        end
        5: program_regs(top_bit($urandom_range(2, W)), rand_bits($urandom_range(0, W)),
                        rand_bits($urandom_range(0, W)), 1'b1);
        default: begin
          calm = 1'b1;
          program_regs(top_bit($urandom_range(2, W)), rand_bits($urandom_range(0, W)),
                       rand_bits($urandom_range(0, W)), 1'b0);
        end
      endcase
      repeat (ITEMS_PER_PHASE)
        send_item($urandom_range(0, 1) ? OP_DECRYPT : OP_ENCRYPT, pick_value(), 1'b0, '0);
    end

    wait_idle();
    repeat (TAIL) @(posedge clk);
    if (awaited_powers.size() != 0) begin
      mismatches++;
      $display("%0d results never arrived", awaited_powers.size());
    end

    $display("Ran %0d transactions (%0d encrypt, %0d decrypt, %0d results) over %0d settings,",
             n_items, n_items - n_dec, n_dec, n_results, n_settings);
    $display("with stall bursts on both sides and a %0d-cycle output hold-off; %0d mismatches.",
             LONG_HOLD, mismatches);
    if (mismatches == 0) begin
      $display("rsa_modular_exponentiation_top test passed");
    end else begin
      $display("rsa_modular_exponentiation_top test failed");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
rtl/rsa_mexp_pkg.sv
rtl/rsa_mexp_dp.sv
rtl/rsa_mexp_ctrl.sv
rtl/rsa_modular_exponentiation_top.sv
rtl/rsa_mexp_checker.sv
sim/rsa_modular_exponentiation_top_tb.sv
